/* design/erf_gaussian_evaluator_defines.svh */
// ----------------------------------------------------------------------------
// erf_gaussian_evaluator_defines.svh
// Assertion macros shared by the erf and Gaussian evaluator.
// ----------------------------------------------------------------------------
`ifndef ERF_GAUSSIAN_EVALUATOR_DEFINES_SVH
`define ERF_GAUSSIAN_EVALUATOR_DEFINES_SVH

`ifndef SYNTHESIS
`define EGE_ASSERT_IMPLY(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("erf_gaussian_evaluator: same-cycle check failed");
`define EGE_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("erf_gaussian_evaluator: next-cycle check failed");
`else
`define EGE_ASSERT_IMPLY(label, clk, rst, pre, post)
`define EGE_ASSERT_NEXT(label, clk, rst, pre, post)
`endif

`endif

/* design/erfge_pkg.sv */
// ----------------------------------------------------------------------------
// erfge_pkg
// Formats, fitted constants and constant helpers of the erf and Gaussian
// evaluator.
// ----------------------------------------------------------------------------
package erfge_pkg;

   localparam int IN_FRAC_BITS  = 24;
   localparam int OUT_FRAC_BITS = 30;
   localparam int POLY_DEGREE   = 7;
   localparam int NUM_COEF      = 2 * (POLY_DEGREE + 1);
   localparam int EXP_TERMS     = 14;
   localparam int RECIP_BITS    = 33;
   localparam int NUM_STAGES    = 4 + RECIP_BITS + 2 * POLY_DEGREE + 4;

   localparam longint unsigned DEC_SCALE = 64'd100000000000000000;

   localparam longint DEC_P1         = 64'sd13150688469405987;
   localparam longint DEC_P2         = 64'sd50466552840922902;
   localparam longint DEC_LOG2E_FRAC = 64'sd44269504088896340;
   localparam longint DEC_LN2        = 64'sd69314718055994530;

   localparam longint DEC_COEF [NUM_COEF] = '{
      64'sd429463428976381402,   64'sd1865143915153509,
      -64'sd1420868456394042349, -64'sd19756010201375526,
      64'sd2362028718318021596,  64'sd89263080906490788,
      -64'sd2224394322043539279, -64'sd205914903824048358,
      64'sd1353812364637492398,  64'sd179205237867671881,
      -64'sd495872327050368255,  64'sd232435844794304634,
      64'sd64814731776613766,    -64'sd568817140081665065,
      -64'sd116492141026395367,  64'sd439226749429304471
   };

   // Converts a decimal constant in units of 1e-17 to Q.32, rounded to nearest with ties away from zero.
   function automatic longint to_q32(input longint v);
      logic        neg;
      logic [63:0] m;
      logic [63:0] ip;
      logic [63:0] rem;
      logic [63:0] fr;
      neg = v < 0;
      m   = neg ? 64'(-v) : 64'(v);
      ip  = m / DEC_SCALE;
      rem = m % DEC_SCALE;
      fr  = '0;
      for (int i = 0; i < 33; i++) begin
         rem = rem << 1;
         fr  = fr << 1;
         if (rem >= DEC_SCALE) begin
            rem = rem - DEC_SCALE;
            fr  = fr | 64'd1;
         end
      end
      fr = (fr + 64'd1) >> 1;
      m  = (ip << 32) + fr;
      return neg ? -longint'(m) : longint'(m);
   endfunction

endpackage

/* design/erf_gaussian_evaluator.sv */
// Throughput: one argument per cycle while the output is not stalled.
// Each reciprocal is a 33-stage restoring divider.
// The whole pipeline holds while a result waits on a stalled output.
// Reset clears the valid bits of all stages; data registers are not reset.
// ----------------------------------------------------------------------------
// erf_gaussian_evaluator
// Evaluates erf(x) and exp(-x*x) for a signed Q7.24 argument in a fixed-point
// pipeline of reciprocals, Horner steps and a Taylor series for the exponent.
// ----------------------------------------------------------------------------
`include "erf_gaussian_evaluator_defines.svh"

module erf_gaussian_evaluator #(
   parameter int IN_FRAC_BITS  = erfge_pkg::IN_FRAC_BITS,
   parameter int OUT_FRAC_BITS = erfge_pkg::OUT_FRAC_BITS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_x,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_erf_value,
   output logic        [31:0] rsp_gauss_value
);
   import erfge_pkg::*;

   localparam logic [32:0] ONE_Q32   = 33'h1_0000_0000;
   localparam logic [31:0] P_Q32 [2] = '{32'(to_q32(DEC_P1)), 32'(to_q32(DEC_P2))};
   localparam logic [31:0] LOG2E_Q32 = 32'(to_q32(DEC_LOG2E_FRAC));
   localparam logic [31:0] LN2_Q32   = 32'(to_q32(DEC_LN2));
   localparam logic [32:0] BIG_LIMIT = 33'(64'd6 << IN_FRAC_BITS);
   localparam int          OUT_SHIFT = 32 - OUT_FRAC_BITS;
   localparam logic [52:0] OUT_ONE   = 53'(64'd1 << OUT_FRAC_BITS);
   localparam logic [52:0] OUT_HALF  = 53'(64'd1 << (OUT_SHIFT - 1));
   localparam logic signed [31:0] ERF_ONE = 32'(64'd1 << OUT_FRAC_BITS);

   function automatic logic [51:0] mulq_mag(input logic [67:0] ph, input logic [67:0] pl);
      logic [67:0] acc;
      acc = ph + (pl >> 16);
      return 52'(acc >> 16);
   endfunction

   logic                    adv;
   logic [NUM_STAGES:1]     vld_ff;
   logic [NUM_STAGES-1:1]   neg_ff;
   logic [NUM_STAGES-1:1]   big_ff;

   assign adv       = !(vld_ff[NUM_STAGES] && rsp_stall);
   assign req_stall = !adv;
   assign rsp_valid = vld_ff[NUM_STAGES];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NUM_STAGES-1:1], req_valid};
      end
   end

   logic [32:0] x_ext;
   logic [32:0] mag_a;
   logic [63:0] a_sh;
   logic        big_in;

   assign x_ext  = {req_x[31], req_x};
   assign mag_a  = req_x[31] ? 33'(-x_ext) : x_ext;
   assign a_sh   = 64'(mag_a) << (28 - IN_FRAC_BITS);
   assign big_in = mag_a >= BIG_LIMIT;

   always_ff @(posedge clock) begin
      if (adv) begin
         neg_ff <= {neg_ff[NUM_STAGES-2:1], req_x[31]};
         big_ff <= {big_ff[NUM_STAGES-2:1], big_in};
      end
   end

   // Front end: magnitude, products with the reciprocal slopes and the square.
   logic [30:0] a28_ff;
   logic [62:0] pa_ff [2];
   logic [61:0] sq_ff;
   logic [34:0] den_ff [2];
   logic [37:0] y_ff;
   logic [34:0] den_in [2];
   logic [37:0] y_in;

   always_comb begin
      for (int c = 0; c < 2; c++) begin
         den_in[c] = 35'(64'(ONE_Q32) + ((64'(pa_ff[c]) + (64'd1 << 27)) >> 28));
      end
      y_in = 38'((64'(sq_ff) + (64'd1 << 23)) >> 24);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a28_ff <= a_sh[30:0];
         for (int c = 0; c < 2; c++) begin
            pa_ff[c]  <= 63'(P_Q32[c]) * 63'(a28_ff);
            den_ff[c] <= den_in[c];
         end
         sq_ff <= 62'(a28_ff) * 62'(a28_ff);
         y_ff  <= y_in;
      end
   end

   // Reciprocals: one quotient bit of floor(2^64 / d) per stage.
   logic [34:0] dv_rem_ff [RECIP_BITS][2];
   logic [32:0] dv_quo_ff [RECIP_BITS][2];
   logic [34:0] dv_den_ff [RECIP_BITS][2];

   for (genvar j = 0; j < RECIP_BITS; j++) begin : g_div
      for (genvar c = 0; c < 2; c++) begin : g_ch
         logic [34:0] rem_prev;
         logic [32:0] quo_prev;
         logic [34:0] den_prev;
         logic [35:0] cand;
         logic        ge;
         logic [34:0] rem_in;
         logic [32:0] quo_in;
         if (j == 0) begin : g_first
            assign rem_prev = 35'(64'd1 << 31);
            assign quo_prev = '0;
            assign den_prev = den_ff[c];
         end else begin : g_next
            assign rem_prev = dv_rem_ff[j-1][c];
            assign quo_prev = dv_quo_ff[j-1][c];
            assign den_prev = dv_den_ff[j-1][c];
         end
         assign cand   = {rem_prev, 1'b0};
         assign ge     = cand >= {1'b0, den_prev};
         assign rem_in = ge ? 35'(cand - {1'b0, den_prev}) : cand[34:0];
         assign quo_in = {quo_prev[31:0], ge};
         always_ff @(posedge clock) begin
            if (adv) begin
               dv_rem_ff[j][c] <= rem_in;
               dv_quo_ff[j][c] <= quo_in;
               dv_den_ff[j][c] <= den_prev;
            end
         end
      end
   end

   // Horner chains, two stages per step.
   logic               hn_neg_ff [POLY_DEGREE][2];
   logic        [67:0] hn_ph_ff  [POLY_DEGREE][2];
   logic        [67:0] hn_pl_ff  [POLY_DEGREE][2];
   logic        [32:0] hn_ta_ff  [POLY_DEGREE][2];
   logic signed [49:0] hn_s_ff   [POLY_DEGREE][2];
   logic        [32:0] hn_tb_ff  [POLY_DEGREE][2];

   for (genvar h = 0; h < POLY_DEGREE; h++) begin : g_poly
      for (genvar c = 0; c < 2; c++) begin : g_ch
         localparam logic signed [49:0] ADD_COEF =
            50'(to_q32(DEC_COEF[(2 * (h + 1) + c) % NUM_COEF]));
         logic signed [49:0] s_prev;
         logic        [32:0] t_prev;
         logic        [49:0] s_mag;
         logic        [51:0] r_mag;
         logic signed [49:0] s_in;
         if (h == 0) begin : g_first
            assign s_prev = 50'(to_q32(DEC_COEF[c]));
            assign t_prev = dv_quo_ff[RECIP_BITS-1][c];
         end else begin : g_next
            assign s_prev = hn_s_ff[h-1][c];
            assign t_prev = hn_tb_ff[h-1][c];
         end
         assign s_mag = s_prev[49] ? 50'(-s_prev) : 50'(s_prev);
         assign r_mag = mulq_mag(hn_ph_ff[h][c], hn_pl_ff[h][c]);
         assign s_in  = 50'(hn_neg_ff[h][c] ? (52'd0 - r_mag) : r_mag) + ADD_COEF;
         always_ff @(posedge clock) begin
            if (adv) begin
               hn_neg_ff[h][c] <= s_prev[49];
               hn_ph_ff[h][c]  <= 68'(s_mag) * 68'(t_prev[32:16]);
               hn_pl_ff[h][c]  <= 68'(s_mag) * 68'(t_prev[15:0]);
               hn_ta_ff[h][c]  <= t_prev;
               hn_s_ff[h][c]   <= s_in;
               hn_tb_ff[h][c]  <= hn_ta_ff[h][c];
            end
         end
      end
   end

   // Exponent front end: z = y * log2(e), split into n and f, g = f * ln2.
   logic [53:0] yph_ff;
   logic [53:0] ypl_ff;
   logic [37:0] y4_ff;
   logic [5:0]  n5_ff;
   logic [31:0] f5_ff;
   logic [47:0] fph_ff;
   logic [47:0] fpl_ff;
   logic [5:0]  n6_ff;
   logic [31:0] g7_ff;
   logic [5:0]  n7_ff;
   logic [39:0] z_in;

   assign z_in = 40'(y4_ff) + 40'((yph_ff + (ypl_ff >> 16)) >> 16);

   always_ff @(posedge clock) begin
      if (adv) begin
         yph_ff <= 54'(y_ff) * 54'(LOG2E_Q32[31:16]);
         ypl_ff <= 54'(y_ff) * 54'(LOG2E_Q32[15:0]);
         y4_ff  <= y_ff;
         n5_ff  <= z_in[37:32];
         f5_ff  <= z_in[31:0];
         fph_ff <= 48'(f5_ff) * 48'(LN2_Q32[31:16]);
         fpl_ff <= 48'(f5_ff) * 48'(LN2_Q32[15:0]);
         n6_ff  <= n5_ff;
         g7_ff  <= 32'((fph_ff + (fpl_ff >> 16)) >> 16);
         n7_ff  <= n6_ff;
      end
   end

   // Taylor series of exp(-g), three stages per term.
   logic [48:0] ex_ph_ff [EXP_TERMS];
   logic [48:0] ex_pl_ff [EXP_TERMS];
   logic [31:0] ex_ga_ff [EXP_TERMS];
   logic [5:0]  ex_na_ff [EXP_TERMS];
   logic [32:0] ex_p_ff  [EXP_TERMS];
   logic [33:0] ex_q0_ff [EXP_TERMS];
   logic [31:0] ex_gb_ff [EXP_TERMS];
   logic [5:0]  ex_nb_ff [EXP_TERMS];
   logic [32:0] ex_r_ff  [EXP_TERMS];
   logic [31:0] ex_gc_ff [EXP_TERMS];
   logic [5:0]  ex_nc_ff [EXP_TERMS];

   for (genvar i = 0; i < EXP_TERMS; i++) begin : g_exp
      localparam int          K       = EXP_TERMS - i;
      localparam logic [36:0] RECIP_K = 37'((64'd1 << 36) / K);
      logic [32:0] r_prev;
      logic [31:0] g_prev;
      logic [5:0]  n_prev;
      logic [32:0] p_in;
      logic [69:0] pm;
      logic [37:0] rem;
      logic [33:0] q;
      logic [32:0] r_in;
      if (i == 0) begin : g_first
         assign r_prev = ONE_Q32;
         assign g_prev = g7_ff;
         assign n_prev = n7_ff;
      end else begin : g_next
         assign r_prev = ex_r_ff[i-1];
         assign g_prev = ex_gc_ff[i-1];
         assign n_prev = ex_nc_ff[i-1];
      end
      assign p_in = 33'((50'(ex_ph_ff[i]) + 50'(ex_pl_ff[i] >> 16)) >> 16);
      assign pm   = 70'(p_in) * 70'(RECIP_K);
      assign rem  = 38'(ex_p_ff[i]) - 38'(ex_q0_ff[i]) * 38'(K);
      assign q    = ex_q0_ff[i] + 34'(rem >= 38'(K));
      assign r_in = 33'(34'(ONE_Q32) - q);
      always_ff @(posedge clock) begin
         if (adv) begin
            ex_ph_ff[i] <= 49'(r_prev) * 49'(g_prev[31:16]);
            ex_pl_ff[i] <= 49'(r_prev) * 49'(g_prev[15:0]);
            ex_ga_ff[i] <= g_prev;
            ex_na_ff[i] <= n_prev;
            ex_p_ff[i]  <= p_in;
            ex_q0_ff[i] <= pm[69:36];
            ex_gb_ff[i] <= ex_ga_ff[i];
            ex_nb_ff[i] <= ex_na_ff[i];
            ex_r_ff[i]  <= r_in;
            ex_gc_ff[i] <= ex_gb_ff[i];
            ex_nc_ff[i] <= ex_nb_ff[i];
         end
      end
   end

   // Scaling by 2^-n, final products and output rounding.
   logic [32:0]  r_last;
   logic [5:0]   n_last;
   logic [32:0]  e32_in;
   logic [31:0]  gauss_in;
   logic [32:0]  e32_ff [3];
   logic [31:0]  gauss_ff [5];
   logic         fm_neg_ff [2];
   logic [67:0]  fm_ph_ff [2];
   logic [67:0]  fm_pl_ff [2];
   logic signed [50:0] sum_ff;
   logic signed [50:0] sum_in;
   logic [50:0]  sum_mag;
   logic         ve_neg_ff;
   logic [67:0]  ve_ph_ff;
   logic [67:0]  ve_pl_ff;
   logic signed [52:0] v_ff;
   logic signed [52:0] v_in;
   logic [51:0]  ve_mag;
   logic [52:0]  v_mag;
   logic [52:0]  v_rnd;
   logic [52:0]  erf_mag;
   logic         erf_sign;
   logic signed [31:0] erf_in;
   logic signed [31:0] erf_ff;
   logic [31:0]  gauss_out_ff;

   assign r_last   = ex_r_ff[EXP_TERMS-1];
   assign n_last   = ex_nc_ff[EXP_TERMS-1];
   assign e32_in   = (n_last == 6'd0) ? r_last
                   : 33'((64'(r_last) + (64'd1 << (n_last - 6'd1))) >> n_last);
   assign gauss_in = 32'((64'(r_last) + (64'd1 << n_last)) >> ({1'b0, n_last} + 7'd1));

   always_comb begin
      logic [51:0] m0;
      logic [51:0] m1;
      m0 = mulq_mag(fm_ph_ff[0], fm_pl_ff[0]);
      m1 = mulq_mag(fm_ph_ff[1], fm_pl_ff[1]);
      sum_in = 51'(fm_neg_ff[0] ? (52'd0 - m0) : m0)
             + 51'(fm_neg_ff[1] ? (52'd0 - m1) : m1);
   end

   assign sum_mag = sum_ff[50] ? 51'(-sum_ff) : 51'(sum_ff);
   assign ve_mag  = mulq_mag(ve_ph_ff, ve_pl_ff);
   assign v_in    = 53'(ONE_Q32) - 53'(ve_neg_ff ? (52'd0 - ve_mag) : ve_mag);
   assign v_mag   = v_ff[52] ? 53'(-v_ff) : 53'(v_ff);
   assign v_rnd   = (v_mag + OUT_HALF) >> OUT_SHIFT;

   always_comb begin
      if (big_ff[NUM_STAGES-1]) begin
         erf_mag  = OUT_ONE;
         erf_sign = neg_ff[NUM_STAGES-1];
      end else begin
         erf_mag  = (v_rnd > OUT_ONE) ? OUT_ONE : v_rnd;
         erf_sign = neg_ff[NUM_STAGES-1] ^ v_ff[52];
      end
      erf_in = erf_sign ? 32'(53'd0 - erf_mag) : 32'(erf_mag);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         e32_ff[0]   <= e32_in;
         e32_ff[1]   <= e32_ff[0];
         e32_ff[2]   <= e32_ff[1];
         gauss_ff[0] <= gauss_in;
         for (int k = 1; k < 5; k++) begin
            gauss_ff[k] <= gauss_ff[k-1];
         end
         for (int c = 0; c < 2; c++) begin
            fm_neg_ff[c] <= hn_s_ff[POLY_DEGREE-1][c][49];
            fm_ph_ff[c]  <= 68'(hn_s_ff[POLY_DEGREE-1][c][49] ?
                                50'(-hn_s_ff[POLY_DEGREE-1][c]) :
                                50'(hn_s_ff[POLY_DEGREE-1][c]))
                          * 68'(hn_tb_ff[POLY_DEGREE-1][c][32:16]);
            fm_pl_ff[c]  <= 68'(hn_s_ff[POLY_DEGREE-1][c][49] ?
                                50'(-hn_s_ff[POLY_DEGREE-1][c]) :
                                50'(hn_s_ff[POLY_DEGREE-1][c]))
                          * 68'(hn_tb_ff[POLY_DEGREE-1][c][15:0]);
         end
         sum_ff       <= sum_in;
         ve_neg_ff    <= sum_ff[50];
         ve_ph_ff     <= 68'(sum_mag) * 68'(e32_ff[2][32:16]);
         ve_pl_ff     <= 68'(sum_mag) * 68'(e32_ff[2][15:0]);
         v_ff         <= v_in;
         erf_ff       <= erf_in;
         gauss_out_ff <= big_ff[NUM_STAGES-1] ? 32'd0 : gauss_ff[4];
      end
   end

   assign rsp_erf_value   = erf_ff;
   assign rsp_gauss_value = gauss_out_ff;

   `EGE_ASSERT_IMPLY(a_erf_range, clock, reset, rsp_valid, (rsp_erf_value <= ERF_ONE) && (rsp_erf_value >= -ERF_ONE))
   `EGE_ASSERT_IMPLY(a_gauss_range, clock, reset, rsp_valid, rsp_gauss_value <= 32'h8000_0000)
   `EGE_ASSERT_IMPLY(a_hold_input, clock, reset, rsp_valid && rsp_stall, req_stall)
   `EGE_ASSERT_NEXT(a_freeze, clock, reset, rsp_valid && rsp_stall, $stable(vld_ff))

endmodule

/* dv/erf_gaussian_evaluator_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// erf_gaussian_evaluator_checker
// Watches both channels of the erf and Gaussian evaluator, predicts erf(x) and
// exp(-x*x) for every accepted argument and compares each result transfer.
// ----------------------------------------------------------------------------
module erf_gaussian_evaluator_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic signed [31:0] req_x,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic signed [31:0] rsp_erf_value,
   input  logic        [31:0] rsp_gauss_value,
   output int                 error_count,
   output int                 pending_count,
   output int                 checked_count
);
   import erfge_pkg::*;

   typedef struct packed {
      logic signed [31:0] erf_value;
      logic        [31:0] gauss_value;
   } erf_result_type;

   erf_result_type expected_results [$];

   function automatic longint dec_to_fixed(input longint v);
      logic         neg;
      logic [127:0] m;
      neg = v < 0;
      m   = {64'd0, neg ? 64'(-v) : 64'(v)};
      m   = ((m << 33) / {64'd0, DEC_SCALE} + 128'd1) >> 1;
      return neg ? -longint'(m[63:0]) : longint'(m[63:0]);
   endfunction

   function automatic longint fixed_mul(input longint s, input logic [63:0] t);
      logic         neg;
      logic [127:0] m;
      neg = s < 0;
      m   = {64'd0, neg ? 64'(-s) : 64'(s)};
      m   = (m * {64'd0, t}) >> 32;
      return neg ? -longint'(m[63:0]) : longint'(m[63:0]);
   endfunction

   function automatic logic [63:0] reciprocal(input logic [63:0] p, input logic [63:0] a28);
      logic [127:0] d;
      d = {64'd0, 64'h1_0000_0000 + ((p * a28 + (64'd1 << 27)) >> 28)};
      return 64'((128'd1 << 64) / d);
   endfunction

   function automatic erf_result_type predict_erf_gauss(input logic signed [31:0] x);
      erf_result_type res;
      logic        neg, vneg;
      logic [63:0] a, a28, t1, t2, y, z, f, g, r, e32, gauss, m;
      longint      s1, s2, sum, v, erf_v;
      int          n;
      neg = x[31];
      a   = neg ? ((64'h1_0000_0000 - {32'd0, x}) & 64'h1_FFFF_FFFF) : {32'd0, x};
      if (a >= (64'd6 << IN_FRAC_BITS)) begin
         erf_v = longint'(1) << OUT_FRAC_BITS;
         gauss = 64'd0;
      end else begin
         a28 = a << (28 - IN_FRAC_BITS);
         t1  = reciprocal(64'(dec_to_fixed(DEC_P1)), a28);
         t2  = reciprocal(64'(dec_to_fixed(DEC_P2)), a28);
         s1  = dec_to_fixed(DEC_COEF[0]);
         s2  = dec_to_fixed(DEC_COEF[1]);
         for (int j = 1; j <= POLY_DEGREE; j++) begin
            s1 = fixed_mul(s1, t1) + dec_to_fixed(DEC_COEF[(2 * j) % NUM_COEF]);
            s2 = fixed_mul(s2, t2) + dec_to_fixed(DEC_COEF[(2 * j + 1) % NUM_COEF]);
         end
         y = (a28 * a28 + (64'd1 << 23)) >> 24;
         z = y + 64'(fixed_mul(longint'(y), 64'(dec_to_fixed(DEC_LOG2E_FRAC))));
         n = int'(z >> 32);
         f = z & 64'hFFFF_FFFF;
         g = 64'(fixed_mul(longint'(f), 64'(dec_to_fixed(DEC_LN2))));
         r = 64'h1_0000_0000;
         for (int k = EXP_TERMS; k >= 1; k--)
            r = 64'h1_0000_0000 - 64'(fixed_mul(longint'(r), g)) / 64'(k);
         if (n > 60)
            n = 60;
         e32   = (n == 0) ? r : (r + (64'd1 << (n - 1))) >> n;
         gauss = (r + (64'd1 << n)) >> (n + 1);
         sum   = fixed_mul(s1, t1) + fixed_mul(s2, t2);
         v     = longint'(64'h1_0000_0000) - fixed_mul(sum, e32);
         vneg  = v < 0;
         m     = vneg ? 64'(-v) : 64'(v);
         m     = (m + (64'd1 << (31 - OUT_FRAC_BITS))) >> (32 - OUT_FRAC_BITS);
         if (m > (64'd1 << OUT_FRAC_BITS))
            m = 64'd1 << OUT_FRAC_BITS;
         erf_v = vneg ? -longint'(m) : longint'(m);
      end
      if (neg)
         erf_v = -erf_v;
      res.erf_value   = erf_v[31:0];
      res.gauss_value = gauss[31:0];
      return res;
   endfunction

   always @(posedge clock) begin
      erf_result_type exp_res;
      if (reset) begin
         expected_results.delete();
         error_count   = 0;
         checked_count = 0;
      end else begin
         if (req_valid && !req_stall)
            expected_results.push_back(predict_erf_gauss(req_x));
         if (rsp_valid && !rsp_stall) begin
            checked_count++;
            if (expected_results.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("ERROR: unexpected result transfer erf=%0d gauss=%0d",
                           rsp_erf_value, rsp_gauss_value);
            end else begin
               exp_res = expected_results.pop_front();
               if (exp_res.erf_value !== rsp_erf_value ||
                   exp_res.gauss_value !== rsp_gauss_value) begin
                  error_count++;
                  if (error_count <= 10)
                     $display("ERROR: expected erf=%0d gauss=%0d, got erf=%0d gauss=%0d",
                              exp_res.erf_value, exp_res.gauss_value,
                              rsp_erf_value, rsp_gauss_value);
               end
            end
         end
      end
      pending_count = expected_results.size();
   end

endmodule

/* dv/erf_gaussian_evaluator_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// erf_gaussian_evaluator_tb
// Drives directed and random arguments into the erf and Gaussian evaluator
// with random gaps and output stalls, including a long output hold-off, and
// reports the verdict from the checker's mismatch and pending counts.
// ----------------------------------------------------------------------------
module erf_gaussian_evaluator_tb;

   localparam int CYCLE_LIMIT  = 500000;
   localparam int RANDOM_ITEMS = 1550;
   localparam int DRAIN_CYCLES = 80;
   localparam int HOLD_CYCLES  = 400;

   logic               clock           = 1'b0;
   logic               reset           = 1'b1;
   logic               req_valid       = 1'b0;
   logic signed [31:0] req_x           = '0;
   logic               rsp_stall       = 1'b0;
   logic               req_stall;
   logic               rsp_valid;
   logic signed [31:0] rsp_erf_value;
   logic        [31:0] rsp_gauss_value;
   int                 error_count;
   int                 pending_count;
   int                 checked_count;
   int                 cycle_count     = 0;
   int                 sent_count      = 0;
   bit                 no_idle         = 1'b0;
   bit                 hold_request    = 1'b0;
   bit                 hold_done       = 1'b0;

   erf_gaussian_evaluator uut (
      .clock, .reset, .req_valid, .req_stall, .req_x,
      .rsp_valid, .rsp_stall, .rsp_erf_value, .rsp_gauss_value
   );

   erf_gaussian_evaluator_checker checker_i (
      .clock, .reset, .req_valid, .req_stall, .req_x,
      .rsp_valid, .rsp_stall, .rsp_erf_value, .rsp_gauss_value,
      .error_count, .pending_count, .checked_count
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic send_argument(input logic signed [31:0] x);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_x     <= x;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent_count++;
   endtask

   function automatic logic signed [31:0] random_argument();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 6)
         return 32'(int'($urandom_range(0, 12 << 24)) - (6 << 24));
      else if (sel < 8)
         return 32'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
      else
         return 32'($urandom);
   endfunction

   always begin
      int n;
      if (reset) begin
         @(posedge clock);
      end else begin
         if (hold_request && !hold_done) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_done = 1'b1;
         end
         n = no_idle ? 0 : $urandom_range(0, 10);
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   initial begin
      logic signed [31:0] directed [$] = '{
         32'sd0, 32'sd1, -32'sd1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001,
         32'sd6 <<< 24, (32'sd6 <<< 24) - 1, -(32'sd6 <<< 24), -(32'sd6 <<< 24) + 1,
         32'sd1 <<< 24, -(32'sd1 <<< 24), 32'sd1 <<< 23, -(32'sd1 <<< 23),
         32'sd2 <<< 24, -(32'sd3 <<< 24), 32'sd5 <<< 24, 32'h0555_5555,
         -32'sh0555_5555, 32'sd7 <<< 24, 32'h00FF_FFFF, 32'sd100
      };
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed[i])
         send_argument(directed[i]);
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         no_idle      = (i >= 300 && i < 500) || (i >= 800 && i < 1000);
         hold_request = hold_request || (i == 320);
         send_argument(random_argument());
      end
      req_valid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Covered %0d arguments (directed edges, sub-six range, small and full-width",
               sent_count);
      $display("values) with %0d results checked under random gaps and a long hold-off.",
               checked_count);
      if (error_count == 0 && pending_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

/* sim.f */
+incdir+design
design/erfge_pkg.sv
design/erf_gaussian_evaluator.sv
dv/erf_gaussian_evaluator_checker.sv
dv/erf_gaussian_evaluator_tb.sv
